// ===== hdl/spq_pkg.sv =====
// shared types and constants for the sorted minimum priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // width of one stored value
    localparam int unsigned VALUE_W = 32;

    // width of the occupancy field
    localparam int unsigned OCC_W = 7;

    // operation codes carried on s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// one storage cell of the sorted chain, smallest value sits in cell 0
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 7
) (
    input  wire                                   aclk,
    input  wire spq_pkg::cell_ctrl_t              ctrl,
    input  wire        [CNT_W-1:0]                count,
    input  wire                                   prev_less,
    input  wire signed [spq_pkg::VALUE_W-1:0]     prev_entry,
    input  wire signed [spq_pkg::VALUE_W-1:0]     next_entry,
    output logic                                  less,
    output logic signed [spq_pkg::VALUE_W-1:0]   entry
);

    logic signed [spq_pkg::VALUE_W-1:0] entry_reg;
    logic signed [spq_pkg::VALUE_W-1:0] entry_next;
    logic                               occupied;

    // cell holds a live entry smaller than the incoming value
    assign occupied = (CNT_W'(INDEX) < count);
    assign less     = occupied && (entry_reg < ctrl.value);
    assign entry    = entry_reg;

    // keep, take the new value, or shift from a neighbor
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (less) begin
                entry_next = entry_reg;
            end else if (prev_less) begin
                entry_next = ctrl.value;
            end else begin
                entry_next = prev_entry;
            end
        end else if (ctrl.rem) begin
            entry_next = next_entry;
        end
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== hdl/sorted_min_priority_queue.sv =====
// top level of the sorted minimum priority queue built from a chain of cells
//
// Bounded priority queue of signed 32-bit values. A request on the s_ channel
// carries the operation on s_tuser (insert or remove smallest) and the value
// on s_tdata. Each request gives exactly one result on the m_ channel with a
// status (done, overflow, underflow), the removed value (zero unless a remove
// succeeded) and the occupancy after the request.
// The values live in a row of DEPTH cells kept in ascending order, smallest in
// cell 0. An insert is broadcast to all cells: each compares itself to the new
// value and keeps its entry, takes the value or takes its lower neighbor's
// entry. A remove shifts every cell down by one.
// An accepted request shows its result on m_tvalid in the next cycle. One request
// is accepted per cycle while the output is not stalled, set by the single
// compare-and-shift step of the cells. Reset clears the occupancy count and the
// output valid; stored values are not cleared, no clearing pass is needed.
// When the receiver stalls the result is held in the output register and
// s_tready drops until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_min_priority_queue #(
    parameter int unsigned DEPTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,    // [31:0] value
    input  wire  [0:0]  s_tuser,    // [0] operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata     // [1:0] status, [33:2] removed_value, [40:34] occupancy
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic                              s_accept;
    logic                              is_full;
    logic                              is_empty;
    logic                              op;
    spq_pkg::cell_ctrl_t               ctrl;
    logic        [CNT_W-1:0]           count_reg;
    logic        [CNT_W-1:0]           count_next;
    logic                              m_valid_reg;
    logic        [1:0]                 status_reg;
    logic        [1:0]                 status_next;
    logic signed [spq_pkg::VALUE_W-1:0] removed_reg;
    logic signed [spq_pkg::VALUE_W-1:0] removed_next;
    logic        [31:0]                count_ext;
    logic        [spq_pkg::OCC_W-1:0]  occupancy_reg;

    logic signed [spq_pkg::VALUE_W-1:0] entry_w [DEPTH];
    logic                               less_w  [DEPTH];

    // request handshake with output register
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign op       = s_tuser[0];
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // command to the cell chain
    always_comb begin
        ctrl.ins   = s_accept && (op == spq_pkg::OP_INSERT) && !is_full;
        ctrl.rem   = s_accept && (op == spq_pkg::OP_REMOVE) && !is_empty;
        ctrl.value = s_tdata;
    end

    // the chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                               prev_less;
        logic signed [spq_pkg::VALUE_W-1:0] prev_entry;
        logic signed [spq_pkg::VALUE_W-1:0] next_entry;

        if (i == 0) begin : g_head
            assign prev_less  = 1'b1;
            assign prev_entry = ctrl.value;
        end else begin : g_body
            assign prev_less  = less_w[i-1];
            assign prev_entry = entry_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_entry = entry_w[i];
        end else begin : g_mid
            assign next_entry = entry_w[i+1];
        end

        spq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .prev_less  (prev_less),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .less       (less_w[i]),
            .entry      (entry_w[i])
        );
    end

    // status, removed value and next count
    always_comb begin
        status_next  = spq_pkg::ST_DONE;
        removed_next = '0;
        count_next   = count_reg;
        if (op == spq_pkg::OP_INSERT) begin
            if (is_full) begin
                status_next = spq_pkg::ST_OVERFLOW;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                status_next = spq_pkg::ST_UNDERFLOW;
            end else begin
                count_next   = count_reg - CNT_W'(1);
                removed_next = entry_w[0];
            end
        end
    end

    assign count_ext = 32'(count_next);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            occupancy_reg <= count_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, occupancy_reg, removed_reg, status_reg};

    // count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy count above capacity");

    // a refused insert leaves the queue unchanged
    a_overflow_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && op == spq_pkg::OP_INSERT && is_full) |=> $stable(count_reg))
        else $error("count changed on overflow");

    // underflow results carry a zero value
    a_underflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == spq_pkg::ST_UNDERFLOW) |-> (removed_reg == '0))
        else $error("nonzero value on underflow");

    // an accepted request always shows a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("missing result after request");

endmodule

`default_nettype wire
